// ===== rtl/core/ptd_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ptd_pkg
// Shared constants for the periodic task dispatcher: table size, opcodes,
// result status codes and index widths.
// ----------------------------------------------------------------------------
package ptd_pkg;

  localparam int SLOTS       = 8;
  localparam int MAX_RESULTS = 8;

  localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CNT_W = $clog2(SLOTS + 1);
  localparam int NUM_W = $clog2(MAX_RESULTS + 1);

  localparam logic [1:0] OP_TICK  = 2'd0;
  localparam logic [1:0] OP_ADD   = 2'd1;
  localparam logic [1:0] OP_PASS  = 2'd2;
  localparam logic [1:0] OP_CLEAR = 2'd3;

  localparam logic [2:0] ST_DONE    = 3'd0;
  localparam logic [2:0] ST_ADDED   = 3'd1;
  localparam logic [2:0] ST_FULL    = 3'd2;
  localparam logic [2:0] ST_DUE     = 3'd3;
  localparam logic [2:0] ST_NOTHING = 3'd4;

  typedef logic [IDX_W-1:0] idx_t;

  function automatic logic [2:0] slot_field(input idx_t idx);
    logic [IDX_W+2:0] w;
    w = (IDX_W + 3)'(idx);
    return w[2:0];
  endfunction

endpackage
`default_nettype wire

// ===== rtl/core/periodic_task_dispatcher.sv =====
// Order: a tick or clear result is registered from S_TICK or S_CLEAR after the transfer; an add
//   result once the scan from slot 0 reaches the first free slot, or the scan end when the
//   table is full; the final pass result from S_FIN once the scan ends; output stalls delay each.
// Throughput: one item at a time, in_ready only when idle, so the next transfer follows the final
//   result; the shared subtract and compare unit takes one slot per cycle unless the output stalls.
// Reset: synchronous, clears the tick count, all slot used bits, the FSM and out_valid.
`default_nettype none
// ----------------------------------------------------------------------------
// periodic_task_dispatcher
// Cooperative periodic task table: tick, add, dispatch pass and clear,
// with a sequential slot scan and a one-entry result lookahead for last.
// ----------------------------------------------------------------------------
module periodic_task_dispatcher import ptd_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  opcode,
  input  wire logic [31:0] period,
  input  wire logic [7:0]  handler,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [2:0]       status,
  output logic [2:0]       slot,
  output logic [7:0]       handler_out,
  output logic [31:0]      stamp,
  output logic             last
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_TICK  = 3'd1;
  localparam logic [2:0] S_ADD   = 3'd2;
  localparam logic [2:0] S_PASS  = 3'd3;
  localparam logic [2:0] S_FIN   = 3'd4;
  localparam logic [2:0] S_CLEAR = 3'd5;

  logic [2:0]       state;
  logic [SLOTS-1:0] slot_used;
  logic [7:0]       slot_handler  [SLOTS];
  logic [31:0]      slot_period   [SLOTS];
  logic [31:0]      slot_last_run [SLOTS];
  logic [31:0]      tick_count;
  logic [31:0]      period_q;
  logic [7:0]       handler_q;
  logic [CNT_W-1:0] scan;
  logic [NUM_W-1:0] n_disp;
  logic             pend_valid;
  idx_t             pend_idx;
  logic [7:0]       pend_handler;

  idx_t        idx;
  logic [31:0] elapsed;
  logic        due;
  logic        scan_end;
  logic        cap;
  logic        ofree;
  logic        load;

  assign idx      = scan[IDX_W-1:0];
  assign elapsed  = tick_count - slot_last_run[idx];
  assign due      = slot_used[idx] && (slot_handler[idx] != 8'd0) &&
                    (elapsed >= slot_period[idx]);
  assign scan_end = (scan == CNT_W'(SLOTS));
  assign cap      = (n_disp == NUM_W'(MAX_RESULTS));
  assign ofree    = !out_valid || out_ready;
  assign in_ready = (state == S_IDLE);

  always_comb begin
    load = 1'b0;
    case (state)
      S_TICK, S_CLEAR, S_FIN: load = ofree;
      S_ADD:   load = ofree && (scan_end || !slot_used[idx]);
      S_PASS:  load = ofree && pend_valid && !scan_end && !cap && due;
      default: load = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      out_valid  <= 1'b0;
      pend_valid <= 1'b0;
      tick_count <= 32'd0;
      slot_used  <= '0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            period_q   <= period;
            handler_q  <= handler;
            scan       <= '0;
            n_disp     <= '0;
            pend_valid <= 1'b0;
            case (opcode)
              OP_TICK:  state <= S_TICK;
              OP_ADD:   state <= S_ADD;
              OP_PASS:  state <= S_PASS;
              OP_CLEAR: state <= S_CLEAR;
              default:  state <= S_IDLE;
            endcase
          end
        end
        S_TICK: begin
          if (ofree) begin
            tick_count  <= tick_count + 32'd1;
            status      <= ST_DONE;
            slot        <= 3'd0;
            handler_out <= 8'd0;
            stamp       <= tick_count + 32'd1;
            last        <= 1'b1;
            state       <= S_IDLE;
          end
        end
        S_CLEAR: begin
          if (ofree) begin
            tick_count  <= 32'd0;
            slot_used   <= '0;
            status      <= ST_DONE;
            slot        <= 3'd0;
            handler_out <= 8'd0;
            stamp       <= 32'd0;
            last        <= 1'b1;
            state       <= S_IDLE;
          end
        end
        S_ADD: begin
          if (scan_end) begin
            if (ofree) begin
              status      <= ST_FULL;
              slot        <= 3'd0;
              handler_out <= 8'd0;
              stamp       <= tick_count;
              last        <= 1'b1;
              state       <= S_IDLE;
            end
          end else if (!slot_used[idx]) begin
            if (ofree) begin
              slot_used[idx]     <= 1'b1;
              slot_handler[idx]  <= handler_q;
              slot_period[idx]   <= period_q;
              slot_last_run[idx] <= 32'd0;
              status             <= ST_ADDED;
              slot               <= slot_field(idx);
              handler_out        <= 8'd0;
              stamp              <= tick_count;
              last               <= 1'b1;
              state              <= S_IDLE;
            end
          end else begin
            scan <= scan + CNT_W'(1);
          end
        end
        S_PASS: begin
          if (scan_end || cap) begin
            state <= S_FIN;
          end else if (!due) begin
            scan <= scan + CNT_W'(1);
          end else if (!pend_valid || ofree) begin
            slot_last_run[idx] <= tick_count;
            if (pend_valid) begin
              status      <= ST_DUE;
              slot        <= slot_field(pend_idx);
              handler_out <= pend_handler;
              stamp       <= tick_count;
              last        <= 1'b0;
            end
            pend_valid   <= 1'b1;
            pend_idx     <= idx;
            pend_handler <= slot_handler[idx];
            n_disp       <= n_disp + NUM_W'(1);
            scan         <= scan + CNT_W'(1);
          end
        end
        S_FIN: begin
          if (ofree) begin
            status      <= pend_valid ? ST_DUE : ST_NOTHING;
            slot        <= pend_valid ? slot_field(pend_idx) : 3'd0;
            handler_out <= pend_valid ? pend_handler : 8'd0;
            stamp       <= tick_count;
            last        <= 1'b1;
            pend_valid  <= 1'b0;
            state       <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire
